[sv/quad_x_motor_mixer_arming_macros.svh]
// Assertion macros for the quad X motor mixer with arming sequence.
// Used by the top-level RTL file quad_x_motor_mixer_arming.sv; expects clk_i and rst_ni in scope.
`ifndef QUAD_X_MOTOR_MIXER_ARMING_MACROS_SVH
`define QUAD_X_MOTOR_MIXER_ARMING_MACROS_SVH

// Checked on every rising edge outside reset.
`define QXMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define QXMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/qxmm_pkg.sv]
// Package for the quad X motor mixer: item types, register file type,
// run mode encoding and reset constants. No dependencies.
package qxmm_pkg;

  localparam int unsigned ThrW   = 12;
  localparam int unsigned DriveW = 12;
  localparam int unsigned DutyW  = 10;
  localparam int unsigned LevelW = 14;  // holds base plus three drives without wrap
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_THROTTLE  = 3'd0,
    CFG_CUTOFF_THROTTLE = 3'd1,
    CFG_THROTTLE_OFFSET = 3'd2,
    CFG_BASE_LIMIT      = 3'd3,
    CFG_DUTY_MAX        = 3'd4
  } cfg_idx_e;

  localparam logic [ThrW-1:0]  StartThrottleRst  = 12'd1100;
  localparam logic [ThrW-1:0]  CutoffThrottleRst = 12'd1020;
  localparam logic [ThrW-1:0]  ThrottleOffsetRst = 12'd1000;
  localparam logic [DutyW-1:0] BaseLimitRst      = 10'd800;
  localparam logic [DutyW-1:0] DutyMaxRst        = 10'd1000;

  typedef enum logic [1:0] {
    MODE_WAIT_ARM = 2'd0,
    MODE_WAIT_THR = 2'd1,
    MODE_RUN      = 2'd2,
    MODE_EXIT     = 2'd3
  } run_mode_e;

  typedef struct packed {
    logic                     armed;
    logic                     altitude_hold;
    logic [ThrW-1:0]          stick_throttle;
    logic signed [DriveW-1:0] altitude_drive;
    logic signed [DriveW-1:0] roll_drive;
    logic signed [DriveW-1:0] pitch_drive;
    logic signed [DriveW-1:0] yaw_drive;
  } in_item_t;

  typedef struct packed {
    logic [DutyW-1:0] duty_front_right_rear;
    logic [DutyW-1:0] duty_two;
    logic [DutyW-1:0] duty_three;
    logic [DutyW-1:0] duty_four;
  } out_item_t;

  typedef struct packed {
    logic [ThrW-1:0]  start_throttle;
    logic [ThrW-1:0]  cutoff_throttle;
    logic [ThrW-1:0]  throttle_offset;
    logic [DutyW-1:0] base_limit;
    logic [DutyW-1:0] duty_max;
  } cfg_t;

  typedef logic signed [LevelW-1:0] level_t;
  typedef level_t levels_t [4];

endpackage

[sv/qxmm_mix.sv]
// Per-tick arming sequence and X-frame mixer: next run mode, next motor
// levels and clamped duties. Purely combinational; depends on qxmm_pkg.
module qxmm_mix
  import qxmm_pkg::*;
(
  input  run_mode_e mode_i,
  input  level_t    levels_i [4],
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output run_mode_e mode_o,
  output level_t    levels_o [4],
  output out_item_t duty_o
);

  logic               thr_start;
  logic               thr_cut;
  logic signed [12:0] base_raw;
  logic [DutyW-1:0]   base;
  level_t             base_l;
  level_t             roll_l;
  level_t             pitch_l;
  level_t             yaw_l;
  level_t             mix [4];
  logic [DutyW-1:0]   duty [4];

  assign thr_start = item_i.stick_throttle > cfg_i.start_throttle;
  assign thr_cut   = item_i.stick_throttle < cfg_i.cutoff_throttle;

  // Next-state logic.
  always_comb begin
    mode_o = mode_i;
    if (!item_i.armed) begin
      mode_o = MODE_WAIT_ARM;
    end else begin
      unique case (mode_i)
        MODE_WAIT_ARM: mode_o = thr_start ? MODE_RUN : MODE_WAIT_THR;
        MODE_WAIT_THR: mode_o = thr_start ? MODE_RUN : MODE_WAIT_THR;
        MODE_RUN:      mode_o = MODE_RUN;
        MODE_EXIT:     mode_o = MODE_WAIT_ARM;
        default:       mode_o = MODE_WAIT_ARM;
      endcase
    end
  end

  // Base drive and mix.
  always_comb begin
    if (item_i.altitude_hold) begin
      base_raw = $signed({item_i.altitude_drive[DriveW-1], item_i.altitude_drive});
    end else begin
      base_raw = $signed({1'b0, item_i.stick_throttle})
               - $signed({1'b0, cfg_i.throttle_offset});
    end
    priority if (base_raw < 13'sd0) begin
      base = '0;
    end else if (base_raw > $signed({3'b000, cfg_i.base_limit})) begin
      base = cfg_i.base_limit;
    end else begin
      base = base_raw[DutyW-1:0];
    end
    base_l  = $signed({4'b0000, base});
    roll_l  = $signed({{2{item_i.roll_drive[DriveW-1]}}, item_i.roll_drive});
    pitch_l = $signed({{2{item_i.pitch_drive[DriveW-1]}}, item_i.pitch_drive});
    yaw_l   = $signed({{2{item_i.yaw_drive[DriveW-1]}}, item_i.yaw_drive});
    mix[0] = base_l + roll_l - pitch_l - yaw_l;
    mix[1] = base_l + roll_l + pitch_l + yaw_l;
    mix[2] = base_l - roll_l + pitch_l - yaw_l;
    mix[3] = base_l - roll_l - pitch_l + yaw_l;
  end

  // Output logic: new motor levels for this tick.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      levels_o[i] = levels_i[i];
    end
    if (!item_i.armed) begin
      for (int i = 0; i < 4; i++) levels_o[i] = '0;
    end else begin
      unique case (mode_i)
        MODE_WAIT_ARM, MODE_EXIT: begin
          for (int i = 0; i < 4; i++) levels_o[i] = '0;
        end
        MODE_WAIT_THR: begin
          for (int i = 0; i < 4; i++) levels_o[i] = levels_i[i];
        end
        MODE_RUN: begin
          // Manual mode below the cutoff stick position stops all motors.
          if (!item_i.altitude_hold && thr_cut) begin
            for (int i = 0; i < 4; i++) levels_o[i] = '0;
          end else begin
            for (int i = 0; i < 4; i++) levels_o[i] = mix[i];
          end
        end
        default: begin
          for (int i = 0; i < 4; i++) levels_o[i] = '0;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      priority if (levels_o[i] < 14'sd0) begin
        duty[i] = '0;
      end else if (levels_o[i] > $signed({4'b0000, cfg_i.duty_max})) begin
        duty[i] = cfg_i.duty_max;
      end else begin
        duty[i] = levels_o[i][DutyW-1:0];
      end
    end
    duty_o.duty_front_right_rear = duty[0];
    duty_o.duty_two              = duty[1];
    duty_o.duty_three            = duty[2];
    duty_o.duty_four             = duty[3];
  end

endmodule

[sv/quad_x_motor_mixer_arming.sv]
// Quad X-frame motor mixer with arming sequence, top level.
// Holds the registers and pipeline; depends on qxmm_pkg, qxmm_mix and the macro header.
//
// One result item per input item. The block takes one item every clock cycle
// as long as results are taken. An accepted item waits in the input register
// while the mode and mix logic work on it. Its result is loaded into the result
// register when the result stage advances, that is once the result register is
// empty or being taken. While a result is stalled, the input register can still
// take one more item. The input stalls only while both registers are full and
// the output is stalled. The run mode and the four motor levels update once per
// item, at the same edge that loads the result register. Consecutive items
// therefore see each other's state without extra delay. Configuration writes are
// always ready, and they take effect on the next item.
`include "quad_x_motor_mixer_arming_macros.svh"

module quad_x_motor_mixer_arming
  import qxmm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      in_valid_q;
  in_item_t  item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  run_mode_e mode_q;
  run_mode_e mode_d;
  level_t    levels_q [4];
  level_t    levels_d [4];
  out_item_t duty_d;
  logic      advance;
  logic      levels_zero;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_throttle  <= StartThrottleRst;
      cfg_q.cutoff_throttle <= CutoffThrottleRst;
      cfg_q.throttle_offset <= ThrottleOffsetRst;
      cfg_q.base_limit      <= BaseLimitRst;
      cfg_q.duty_max        <= DutyMaxRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_THROTTLE:  cfg_q.start_throttle  <= cfg_data_i;
        CFG_CUTOFF_THROTTLE: cfg_q.cutoff_throttle <= cfg_data_i;
        CFG_THROTTLE_OFFSET: cfg_q.throttle_offset <= cfg_data_i;
        CFG_BASE_LIMIT:      cfg_q.base_limit      <= cfg_data_i[DutyW-1:0];
        CFG_DUTY_MAX:        cfg_q.duty_max        <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // The result stage moves whenever its register is empty or being taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  qxmm_mix u_mix (
    .mode_i   (mode_q),
    .levels_i (levels_q),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .mode_o   (mode_d),
    .levels_o (levels_d),
    .duty_o   (duty_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_WAIT_ARM;
      levels_q    <= '{default: '0};
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        mode_q   <= mode_d;
        levels_q <= levels_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_item_q <= duty_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign levels_zero = (levels_q[0] == '0) && (levels_q[1] == '0) &&
                       (levels_q[2] == '0) && (levels_q[3] == '0);

  `QXMM_ASSERT(a_no_stored_exit, mode_q != MODE_EXIT, "exit mode was stored")
  `QXMM_ASSERT(a_disarm_zeroes, (advance && in_valid_q && !item_q.armed) |=> (mode_q == MODE_WAIT_ARM && levels_zero), "disarm did not stop the motors")
  `QXMM_ASSERT(a_wait_arm_idle, (mode_q == MODE_WAIT_ARM) |-> levels_zero, "motor levels nonzero while waiting for arm")
  `QXMM_ASSERT(a_stage_moves, (in_valid_q && advance) |=> out_valid_q, "item lost between stages")
  `QXMM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> (!out_valid_o && !in_stall_o), "pipeline not empty in reset")

endmodule

[verif/quad_x_motor_mixer_arming_test.sv]
// Self-checking testbench for quad_x_motor_mixer_arming: drives control ticks and
// register writes, predicts the four motor duties and compares every result item.
// Depends on qxmm_pkg and the quad_x_motor_mixer_arming RTL.
module quad_x_motor_mixer_arming_test
  import qxmm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the arming sequence and motor levels, and holds the expected duties.
  class motor_duty_board;
    cfg_t       regs;
    run_mode_e  mode;
    int         levels [4];
    out_item_t  duty_queue [$];
    string      motor_names [4];
    int         errors, ticks, results, mixes, holds, cutoffs, disarms;

    function new();
      regs = '{StartThrottleRst, CutoffThrottleRst, ThrottleOffsetRst, BaseLimitRst,
               DutyMaxRst};
      mode = MODE_WAIT_ARM;
      levels = '{default: 0};
      motor_names = '{"duty_front_right_rear", "duty_two", "duty_three", "duty_four"};
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_START_THROTTLE:  regs.start_throttle  = data;
        CFG_CUTOFF_THROTTLE: regs.cutoff_throttle = data;
        CFG_THROTTLE_OFFSET: regs.throttle_offset = data;
        CFG_BASE_LIMIT:      regs.base_limit      = data[DutyW-1:0];
        CFG_DUTY_MAX:        regs.duty_max        = data[DutyW-1:0];
        default: ;
      endcase
    endfunction

    function out_item_t mix_tick(in_item_t it);
      int thr, alt, roll, pitch, yaw, base;
      bit mix_now;
      logic [$bits(out_item_t)-1:0] duties;
      thr   = int'(it.stick_throttle);
      alt   = int'($signed(it.altitude_drive));
      roll  = int'($signed(it.roll_drive));
      pitch = int'($signed(it.pitch_drive));
      yaw   = int'($signed(it.yaw_drive));
      base  = 0;
      mix_now = 1'b0;
      if (!it.armed) begin
        mode = MODE_EXIT;
        disarms++;
      end
      case (mode)
        MODE_WAIT_ARM: begin
          // Arming checks the throttle in the same tick, so a high stick runs at once.
          levels = '{default: 0};
          mode = MODE_WAIT_THR;
          if (thr > int'(regs.start_throttle)) mode = MODE_RUN;
        end
        MODE_WAIT_THR: begin
          if (thr > int'(regs.start_throttle)) mode = MODE_RUN;
        end
        MODE_RUN: begin
          if (it.altitude_hold) begin
            base = alt;
            mix_now = 1'b1;
            holds++;
          end else if (thr < int'(regs.cutoff_throttle)) begin
            levels = '{default: 0};
            cutoffs++;
          end else begin
            base = thr - int'(regs.throttle_offset);
            mix_now = 1'b1;
          end
        end
        default: begin
          levels = '{default: 0};
          mode = MODE_WAIT_ARM;
        end
      endcase
      if (mix_now) begin
        base = clamp(base, 0, int'(regs.base_limit));
        levels[0] = base + roll - pitch - yaw;
        levels[1] = base + roll + pitch + yaw;
        levels[2] = base - roll + pitch - yaw;
        levels[3] = base - roll - pitch + yaw;
        mixes++;
      end
      for (int m = 0; m < 4; m++) begin
        duties[(3-m)*DutyW +: DutyW] = DutyW'(clamp(levels[m], 0, int'(regs.duty_max)));
      end
      return out_item_t'(duties);
    endfunction

    function void note_tick(in_item_t it);
      duty_queue.push_back(mix_tick(it));
      ticks++;
    endfunction

    function void check_duties(out_item_t got);
      logic [$bits(out_item_t)-1:0] got_bits, want_bits;
      results++;
      if (duty_queue.size() == 0) begin
        errors++;
        $display("%0t: result item %h arrived with nothing expected", $time, got);
        return;
      end
      want_bits = duty_queue.pop_front();
      got_bits = got;
      for (int m = 0; m < 4; m++) begin
        if (got_bits[(3-m)*DutyW +: DutyW] !== want_bits[(3-m)*DutyW +: DutyW]) begin
          errors++;
          $display("%0t: %s expected %0d actual %0d", $time, motor_names[m],
                   want_bits[(3-m)*DutyW +: DutyW], got_bits[(3-m)*DutyW +: DutyW]);
        end
      end
    endfunction

    function int pending();
      return duty_queue.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  motor_duty_board board;
  int burst_left = 0;
  int stall_tick = 0;
  int stall_style = 0;
  int settings_run = 1;

  quad_x_motor_mixer_arming DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The receiver switches between no stall, light stall and heavy stall.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 48 == 0) stall_style <= $urandom_range(0, 2);
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Inputs are noted before results are checked; a result never shares an edge
  // with its own item.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) board.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) board.note_tick(in_item_i);
      if (out_valid_o && !out_stall_i) board.check_duties(out_item_o);
    end
  end

  function automatic in_item_t tick_of(logic armed, logic hold, int thr, int alt,
                                       int roll, int pitch, int yaw);
    in_item_t it;
    it.armed          = armed;
    it.altitude_hold  = hold;
    it.stick_throttle = ThrW'(thr);
    it.altitude_drive = DriveW'(alt);
    it.roll_drive     = DriveW'(roll);
    it.pitch_drive    = DriveW'(pitch);
    it.yaw_drive      = DriveW'(yaw);
    return it;
  endfunction

  // Mostly armed flight with moderate drives; some items are pure noise.
  function automatic in_item_t random_tick();
    in_item_t it;
    logic [63:0] raw;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      raw = {$urandom, $urandom};
      it = raw[$bits(in_item_t)-1:0];
    end else begin
      it.armed          = ($urandom_range(0, 39) != 0);
      it.altitude_hold  = ($urandom_range(0, 2) == 0);
      it.stick_throttle = (pick == 1) ? ThrW'($urandom) : ThrW'($urandom_range(900, 2100));
      it.altitude_drive = DriveW'(int'($urandom_range(0, 1200)) - 200);
      if (pick == 2) begin
        it.roll_drive  = DriveW'($urandom);
        it.pitch_drive = DriveW'($urandom);
        it.yaw_drive   = DriveW'($urandom);
      end else begin
        it.roll_drive  = DriveW'(int'($urandom_range(0, 600)) - 300);
        it.pitch_drive = DriveW'(int'($urandom_range(0, 600)) - 300);
        it.yaw_drive   = DriveW'(int'($urandom_range(0, 600)) - 300);
      end
    end
    return it;
  endfunction

  // Called at a rising edge; returns once the item is accepted and any gap after it.
  task automatic send_tick(input in_item_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_tick(random_tick());
      if (i == count / 2) drain();
    end
  endtask

  // Writes all five registers, plus one index past the end that must be ignored.
  task automatic program_regs(input logic [CfgDataW-1:0] st, co, off, bl, dm);
    logic [CfgIdxW-1:0]  slots [6];
    logic [CfgDataW-1:0] vals [6];
    slots[0] = CfgIdxW'($urandom_range(int'(CFG_DUTY_MAX) + 1, (1 << CfgIdxW) - 1));
    vals[0]  = CfgDataW'($urandom);
    slots[1] = CFG_START_THROTTLE;  vals[1] = st;
    slots[2] = CFG_CUTOFF_THROTTLE; vals[2] = co;
    slots[3] = CFG_THROTTLE_OFFSET; vals[3] = off;
    slots[4] = CFG_BASE_LIMIT;      vals[4] = bl;
    slots[5] = CFG_DUTY_MAX;        vals[5] = dm;
    for (int k = 0; k < 6; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= slots[k];
      cfg_data_i  <= vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  initial begin
    logic [CfgDataW-1:0] st, co, off, bl, dm;
    board = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_START_THROTTLE;
    cfg_data_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks under the reset register values.
    send_tick(tick_of(1'b0, 1'b0, 0, 0, 0, 0, 0));
    send_tick(tick_of(1'b1, 1'b0, 1000, 0, 5, 5, 5));
    send_tick(tick_of(1'b1, 1'b0, 1100, 0, 5, 5, 5));
    send_tick(tick_of(1'b1, 1'b0, 1101, 0, 5, 5, 5));
    send_tick(tick_of(1'b1, 1'b0, 1500, 0, 10, 20, 30));
    send_tick(tick_of(1'b1, 1'b0, 1019, 0, 10, 20, 30));
    send_tick(tick_of(1'b1, 1'b0, 1020, 0, 0, 0, 0));
    send_tick(tick_of(1'b1, 1'b0, 4095, 0, 2047, -2048, 2047));
    send_tick(tick_of(1'b1, 1'b0, 4095, 0, -2048, 2047, -2048));
    send_tick(tick_of(1'b1, 1'b1, 1500, -2048, 40, -30, 20));
    send_tick(tick_of(1'b1, 1'b1, 1500, 2047, 200, 0, 0));
    send_tick(tick_of(1'b1, 1'b1, 1500, 500, 0, 0, 0));
    send_tick(tick_of(1'b1, 1'b1, 0, 300, -50, 60, -70));
    send_tick(tick_of(1'b0, 1'b1, 1500, 300, 10, 10, 10));
    send_tick(tick_of(1'b1, 1'b0, 4095, 0, 100, 100, 100));
    send_tick(tick_of(1'b1, 1'b0, 1600, 0, -100, -100, -100));
    send_tick(tick_of(1'b1, 1'b0, 0, 0, 100, 100, 100));
    send_tick(tick_of(1'b0, 1'b0, 4095, 2047, 2047, 2047, 2047));
    send_tick(tick_of(1'b0, 1'b1, 0, -2048, -2048, -2048, -2048));
    send_tick(tick_of(1'b1, 1'b0, 1200, 0, 0, 0, 0));
    send_tick(tick_of(1'b1, 1'b1, 1200, 0, -2048, -2048, -2048));
    run_random(150);
    drain();

    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: begin
          st = '0; co = '0; off = '0; bl = '0; dm = '1;
        end
        2: begin
          st = '1; co = '1; off = '1; bl = '1; dm = '0;
        end
        3: begin
          st  = CfgDataW'($urandom_range(1050, 1300));
          co  = CfgDataW'($urandom_range(950, 1100));
          off = CfgDataW'($urandom_range(900, 1100));
          bl  = CfgDataW'($urandom_range(300, 1023));
          dm  = CfgDataW'($urandom_range(200, 1023));
        end
        4: begin
          st = CfgDataW'($urandom); co = CfgDataW'($urandom); off = CfgDataW'($urandom);
          bl = CfgDataW'($urandom); dm = CfgDataW'($urandom);
        end
        default: begin
          st = StartThrottleRst; co = CutoffThrottleRst; off = ThrottleOffsetRst;
          bl = CfgDataW'(BaseLimitRst); dm = CfgDataW'(DutyMaxRst);
        end
      endcase
      program_regs(st, co, off, bl, dm);
      run_random((phase == 3) ? 180 : 130);
      drain();
    end

    $display("Ran %0d ticks under %0d register settings; %0d result items checked.",
             board.ticks, settings_run, board.results);
    $display("Mixed %0d ticks (%0d in altitude hold), %0d at cutoff, %0d while disarmed.",
             board.mixes, board.holds, board.cutoffs, board.disarms);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run did not finish in time.");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
